// ===== rtl/pfbi_pkg.sv =====
package pfbi_pkg;

  localparam int LIMB_W    = 64;
  localparam int NUM_LIMBS = 6;
  localparam int ELEM_W    = LIMB_W * NUM_LIMBS;
  localparam int EXP_IW    = 9;

  localparam logic [1:0] FIELD_SECP = 2'd0;
  localparam logic [1:0] FIELD_BN   = 2'd1;
  localparam logic [1:0] FIELD_BLS  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  typedef enum logic [1:0] {
    PW_ELEM  = 2'd0,
    PW_MUL   = 2'd1,
    PW_TOTAL = 2'd2
  } pf_wsel_t;

  typedef enum logic [1:0] {
    MA_PF    = 2'd0,
    MA_TOTAL = 2'd1,
    MA_BASE  = 2'd2
  } mul_a_t;

  typedef enum logic [1:0] {
    MB_ELEM = 2'd0,
    MB_BASE = 2'd1,
    MB_PF   = 2'd2,
    MB_EL   = 2'd3
  } mul_b_t;

  typedef struct packed {
    logic              latch_in;
    logic              el_we;
    logic              pf_we;
    pf_wsel_t          pf_wsel;
    logic              mul_start;
    mul_a_t            a_sel;
    mul_b_t            b_sel;
    logic              total_one;
    logic              total_mul;
    logic              base_pd;
    logic              base_mul;
    logic              out_ld;
    logic              out_err;
    logic [1:0]        out_status;
    logic [EXP_IW-1:0] exp_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic is_zero;
    logic mul_done;
    logic exp_bit;
  } dp_stat_t;

  // unused selector code falls back to secp256k1
  function automatic logic [1:0] norm_field(input logic [1:0] sel);
    return (sel == FIELD_BN || sel == FIELD_BLS) ? sel : FIELD_SECP;
  endfunction

  function automatic logic [ELEM_W-1:0] prime_of(input logic [1:0] sel);
    logic [ELEM_W-1:0] p;
    case (sel)
      FIELD_BN: p = {128'd0, 64'h30644E72E131A029, 64'hB85045B68181585D,
                     64'h97816A916871CA8D, 64'h3C208C16D87CFD47};
      FIELD_BLS: p = {64'h1A0111EA397FE69A, 64'h4B1BA7B6434BACD7,
                      64'h64774B84F38512BF, 64'h6730D2A0F6B0F624,
                      64'h1EABFFFEB153FFFF, 64'hB9FEFFFFFFFFAAAB};
      default: p = {128'd0, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
                    64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFEFFFFFC2F};
    endcase
    return p;
  endfunction

  function automatic logic [ELEM_W-1:0] exp_of(input logic [1:0] sel);
    return prime_of(sel) - ELEM_W'(2);
  endfunction

endpackage

// ===== rtl/pfbi_in_if.sv =====
interface pfbi_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] limb_0;
  logic [63:0] limb_1;
  logic [63:0] limb_2;
  logic [63:0] limb_3;
  logic [63:0] limb_4;
  logic [63:0] limb_5;
  logic        is_last;

  modport source (output valid, limb_0, limb_1, limb_2, limb_3, limb_4, limb_5, is_last,
                  input ready);
  modport sink (input valid, limb_0, limb_1, limb_2, limb_3, limb_4, limb_5, is_last,
                output ready);
endinterface

// ===== rtl/pfbi_out_if.sv =====
interface pfbi_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] inv_limb_0;
  logic [63:0] inv_limb_1;
  logic [63:0] inv_limb_2;
  logic [63:0] inv_limb_3;
  logic [63:0] inv_limb_4;
  logic [63:0] inv_limb_5;
  logic [1:0]  status;
  logic        last_result;

  modport source (output valid, inv_limb_0, inv_limb_1, inv_limb_2, inv_limb_3, inv_limb_4,
                  inv_limb_5, status, last_result, input ready);
  modport sink (input valid, inv_limb_0, inv_limb_1, inv_limb_2, inv_limb_3, inv_limb_4,
                inv_limb_5, status, last_result, output ready);
endinterface

// ===== rtl/pfbi_cfg_if.sv =====
interface pfbi_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] field_select;

  modport source (output valid, field_select, input ready);
  modport sink (input valid, field_select, output ready);
endinterface

// ===== rtl/prime_field_batch_inverter_core.sv =====
// Batch inverter over a selectable prime field (secp256k1, BN254 or BLS12-381 base
// prime, picked by field_select; code 3 acts as secp256k1). Each element word is
// stored with its running prefix product; the word with is_last closes the batch,
// the total is inverted by Fermat exponentiation and the prefixes are walked back,
// so that the inverses come out one result word per element in input order. A zero
// element or an overlong batch gives one error word instead. All arithmetic runs
// on one bit-serial modular multiplier, which reduces the first operand bit by bit
// and then doubles and conditionally adds for each bit of the second. A non-final
// element costs one prefix product, the first one of a batch none. The last element
// adds 384 squarings plus one product per set bit of p-2, then 2*(n-1) walk products,
// then each result word is read back and offered, held while the output
// stalls. Only one element is in the block at a time; field_select may change only
// while it is idle.
module prime_field_batch_inverter_core import pfbi_pkg::*; #(
  parameter int MAX_BATCH = 64
) (
  input  logic      clk,
  input  logic      rst,
  pfbi_in_if.sink   elem,
  pfbi_out_if.source result,
  pfbi_cfg_if.sink  cfg
);
  localparam int AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

  dp_cmd_t           cmd;
  dp_stat_t          stat;
  logic [AW-1:0]     waddr;
  logic [AW-1:0]     el_raddr;
  logic [AW-1:0]     pf_raddr;
  logic [ELEM_W-1:0] in_word;
  logic [ELEM_W-1:0] out_word;
  logic [1:0]        out_status;
  logic              in_ready;
  logic              out_valid;
  logic              out_last;

  assign in_word = {elem.limb_5, elem.limb_4, elem.limb_3,
                    elem.limb_2, elem.limb_1, elem.limb_0};
  assign cfg.ready = 1'b1;

  pfbi_ctrl #(.MAX_BATCH(MAX_BATCH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (elem.valid),
    .in_last   (elem.is_last),
    .in_ready  (in_ready),
    .out_ready (result.ready),
    .out_valid (out_valid),
    .out_last  (out_last),
    .cmd       (cmd),
    .waddr     (waddr),
    .el_raddr  (el_raddr),
    .pf_raddr  (pf_raddr),
    .stat      (stat)
  );

  pfbi_datapath #(.MAX_BATCH(MAX_BATCH)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg.valid),
    .cfg_data   (cfg.field_select),
    .in_word    (in_word),
    .cmd        (cmd),
    .waddr      (waddr),
    .el_raddr   (el_raddr),
    .pf_raddr   (pf_raddr),
    .stat       (stat),
    .out_word   (out_word),
    .out_status (out_status)
  );

  assign elem.ready         = in_ready;
  assign result.valid       = out_valid;
  assign result.last_result = out_last;
  assign result.status      = out_status;
  assign result.inv_limb_0  = out_word[0*LIMB_W +: LIMB_W];
  assign result.inv_limb_1  = out_word[1*LIMB_W +: LIMB_W];
  assign result.inv_limb_2  = out_word[2*LIMB_W +: LIMB_W];
  assign result.inv_limb_3  = out_word[3*LIMB_W +: LIMB_W];
  assign result.inv_limb_4  = out_word[4*LIMB_W +: LIMB_W];
  assign result.inv_limb_5  = out_word[5*LIMB_W +: LIMB_W];
endmodule

// ===== rtl/pfbi_ram.sv =====
module pfbi_ram #(
  parameter int WIDTH = 384,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/pfbi_modmul.sv =====
module pfbi_modmul import pfbi_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ELEM_W-1:0] a,
  input  logic [ELEM_W-1:0] b,
  input  logic [ELEM_W-1:0] p,
  output logic              done,
  output logic [ELEM_W-1:0] result
);
  localparam int XW = ELEM_W + 2;

  typedef enum logic [3:0] {
    M_IDLE = 4'b0001,
    M_RED  = 4'b0010,
    M_DBL  = 4'b0100,
    M_ADD  = 4'b1000
  } mm_state_t;

  mm_state_t         state;
  logic [EXP_IW-1:0] cnt;
  logic [ELEM_W-1:0] ashift;
  logic [ELEM_W-1:0] bshift;
  logic [ELEM_W-1:0] ar;
  logic [ELEM_W-1:0] acc;
  logic [XW-1:0]     x;
  logic [XW-1:0]     d;
  logic [ELEM_W-1:0] red;

  // shared step: x < 2p, so one conditional subtract brings it back below p
  always_comb begin
    unique case (state)
      M_RED:   x = {1'b0, acc, ashift[ELEM_W-1]};
      M_DBL:   x = {1'b0, acc, 1'b0};
      M_ADD:   x = {2'b00, acc} + (bshift[ELEM_W-1] ? {2'b00, ar} : XW'(0));
      default: x = '0;
    endcase
    d   = x - {2'b00, p};
    red = d[XW-1] ? x[ELEM_W-1:0] : d[ELEM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            ashift <= a;
            bshift <= b;
            acc    <= '0;
            cnt    <= EXP_IW'(ELEM_W - 1);
            state  <= M_RED;
          end
        end
        M_RED: begin
          ashift <= ashift << 1;
          if (cnt == '0) begin
            ar    <= red;
            acc   <= '0;
            cnt   <= EXP_IW'(ELEM_W - 1);
            state <= M_DBL;
          end else begin
            acc <= red;
            cnt <= cnt - 1'b1;
          end
        end
        M_DBL: begin
          acc   <= red;
          state <= M_ADD;
        end
        M_ADD: begin
          acc    <= red;
          bshift <= bshift << 1;
          if (cnt == '0) begin
            done  <= 1'b1;
            state <= M_IDLE;
          end else begin
            cnt   <= cnt - 1'b1;
            state <= M_DBL;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign result = acc;
endmodule

// ===== rtl/pfbi_datapath.sv =====
module pfbi_datapath import pfbi_pkg::*; #(
  parameter int MAX_BATCH = 64,
  localparam int AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_data,
  input  logic [ELEM_W-1:0] in_word,
  input  dp_cmd_t           cmd,
  input  logic [AW-1:0]     waddr,
  input  logic [AW-1:0]     el_raddr,
  input  logic [AW-1:0]     pf_raddr,
  output dp_stat_t          stat,
  output logic [ELEM_W-1:0] out_word,
  output logic [1:0]        out_status
);
  logic [1:0]        cfg_field;
  logic [1:0]        psel;
  logic [1:0]        in_sel;
  logic [ELEM_W-1:0] elem;
  logic [ELEM_W-1:0] total;
  logic [ELEM_W-1:0] base;
  logic [ELEM_W-1:0] el_rd;
  logic [ELEM_W-1:0] pf_rd;
  logic [ELEM_W-1:0] pf_wdata;
  logic [ELEM_W-1:0] mul_a;
  logic [ELEM_W-1:0] mul_b;
  logic [ELEM_W-1:0] mul_res;
  logic [ELEM_W-1:0] exp_word;
  logic              mul_done;

  assign in_sel = norm_field(cfg_field);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_field <= FIELD_SECP;
    end else if (cfg_we) begin
      cfg_field <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      psel <= in_sel;
      // upper limbs only count for the 384-bit field
      elem <= (in_sel == FIELD_BLS) ? in_word
                                    : {{(ELEM_W - 256){1'b0}}, in_word[255:0]};
    end
    if (cmd.total_one) begin
      total <= ELEM_W'(1);
    end else if (cmd.total_mul) begin
      total <= mul_res;
    end
    if (cmd.base_pd) begin
      base <= pf_rd;
    end else if (cmd.base_mul) begin
      base <= mul_res;
    end
    if (cmd.out_ld) begin
      out_word   <= cmd.out_err ? '0 : pf_rd;
      out_status <= cmd.out_status;
    end
  end

  always_comb begin
    case (cmd.pf_wsel)
      PW_MUL:   pf_wdata = mul_res;
      PW_TOTAL: pf_wdata = total;
      default:  pf_wdata = elem;
    endcase
    case (cmd.a_sel)
      MA_TOTAL: mul_a = total;
      MA_BASE:  mul_a = base;
      default:  mul_a = pf_rd;
    endcase
    case (cmd.b_sel)
      MB_BASE: mul_b = base;
      MB_PF:   mul_b = pf_rd;
      MB_EL:   mul_b = el_rd;
      default: mul_b = elem;
    endcase
  end

  assign exp_word = exp_of(psel);

  assign stat.is_zero  = (elem == '0);
  assign stat.mul_done = mul_done;
  assign stat.exp_bit  = exp_word[cmd.exp_idx];

  pfbi_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_BATCH)) u_el_ram (
    .clk   (clk),
    .we    (cmd.el_we),
    .waddr (waddr),
    .wdata (elem),
    .raddr (el_raddr),
    .rdata (el_rd)
  );

  pfbi_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_BATCH)) u_pf_ram (
    .clk   (clk),
    .we    (cmd.pf_we),
    .waddr (waddr),
    .wdata (pf_wdata),
    .raddr (pf_raddr),
    .rdata (pf_rd)
  );

  pfbi_modmul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .p      (prime_of(psel)),
    .done   (mul_done),
    .result (mul_res)
  );
endmodule

// ===== rtl/pfbi_ctrl.sv =====
module pfbi_ctrl import pfbi_pkg::*; #(
  parameter int MAX_BATCH = 64,
  localparam int AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  output logic          out_last,
  output dp_cmd_t       cmd,
  output logic [AW-1:0] waddr,
  output logic [AW-1:0] el_raddr,
  output logic [AW-1:0] pf_raddr,
  input  dp_stat_t      stat
);
  localparam int CW = $clog2(MAX_BATCH + 1);

  typedef enum logic [16:0] {
    S_IDLE    = 17'b00000000000000001,
    S_STORE   = 17'b00000000000000010,
    S_PF_RD   = 17'b00000000000000100,
    S_PF_WAIT = 17'b00000000000001000,
    S_CHECK   = 17'b00000000000010000,
    S_INV_LD  = 17'b00000000000100000,
    S_EXP     = 17'b00000000001000000,
    S_EXP_MW  = 17'b00000000010000000,
    S_SQ_GO   = 17'b00000000100000000,
    S_SQ_MW   = 17'b00000001000000000,
    S_WALK    = 17'b00000010000000000,
    S_WALK_RD = 17'b00000100000000000,
    S_W1_MW   = 17'b00001000000000000,
    S_W2_GO   = 17'b00010000000000000,
    S_W2_MW   = 17'b00100000000000000,
    S_EMIT_RD = 17'b01000000000000000,
    S_OUT     = 17'b10000000000000000
  } ctrl_state_t;

  ctrl_state_t       state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     idx, idx_next;
  logic [EXP_IW-1:0] eidx, eidx_next;
  logic              last_l, last_l_next;
  logic              zero_seen, zero_seen_next;
  logic              ovf_seen, ovf_seen_next;
  logic              out_last_r, out_last_next;
  logic              emit_ld, emit_ld_next;
  logic [CW-1:0]     cm1;

  assign cm1 = count - CW'(1);

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    eidx_next      = eidx;
    last_l_next    = last_l;
    zero_seen_next = zero_seen;
    ovf_seen_next  = ovf_seen;
    out_last_next  = out_last_r;
    emit_ld_next   = 1'b0;
    cmd            = '0;
    cmd.exp_idx    = eidx;
    cmd.out_status = ST_OK;
    waddr          = count[AW-1:0];
    el_raddr       = idx;
    pf_raddr       = cm1[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          last_l_next  = in_last;
          state_next   = S_STORE;
        end
      end
      S_STORE: begin
        if (count == CW'(MAX_BATCH)) begin
          ovf_seen_next = 1'b1;
          state_next    = S_CHECK;
        end else begin
          cmd.el_we = 1'b1;
          if (stat.is_zero) begin
            zero_seen_next = 1'b1;
          end
          if (count == '0) begin
            cmd.pf_we   = 1'b1;
            cmd.pf_wsel = PW_ELEM;
            count_next  = count + CW'(1);
            state_next  = S_CHECK;
          end else begin
            state_next = S_PF_RD;
          end
        end
      end
      S_PF_RD: begin
        cmd.mul_start = 1'b1;
        cmd.a_sel     = MA_PF;
        cmd.b_sel     = MB_ELEM;
        state_next    = S_PF_WAIT;
      end
      S_PF_WAIT: begin
        if (stat.mul_done) begin
          cmd.pf_we   = 1'b1;
          cmd.pf_wsel = PW_MUL;
          count_next  = count + CW'(1);
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        // prefix of the last stored item is being read here for the inversion
        if (!last_l) begin
          state_next = S_IDLE;
        end else if (ovf_seen || zero_seen) begin
          cmd.out_ld     = 1'b1;
          cmd.out_err    = 1'b1;
          cmd.out_status = ovf_seen ? ST_LONG : ST_ZERO;
          out_last_next  = 1'b1;
          state_next     = S_OUT;
        end else begin
          state_next = S_INV_LD;
        end
      end
      S_INV_LD: begin
        cmd.total_one = 1'b1;
        cmd.base_pd   = 1'b1;
        eidx_next     = '0;
        idx_next      = cm1[AW-1:0];
        state_next    = S_EXP;
      end
      S_EXP: begin
        if (stat.exp_bit) begin
          cmd.mul_start = 1'b1;
          cmd.a_sel     = MA_TOTAL;
          cmd.b_sel     = MB_BASE;
          state_next    = S_EXP_MW;
        end else begin
          state_next = S_SQ_GO;
        end
      end
      S_EXP_MW: begin
        if (stat.mul_done) begin
          cmd.total_mul = 1'b1;
          state_next    = S_SQ_GO;
        end
      end
      S_SQ_GO: begin
        cmd.mul_start = 1'b1;
        cmd.a_sel     = MA_BASE;
        cmd.b_sel     = MB_BASE;
        state_next    = S_SQ_MW;
      end
      S_SQ_MW: begin
        if (stat.mul_done) begin
          cmd.base_mul = 1'b1;
          if (eidx == EXP_IW'(ELEM_W - 1)) begin
            state_next = S_WALK;
          end else begin
            eidx_next  = eidx + 1'b1;
            state_next = S_EXP;
          end
        end
      end
      S_WALK: begin
        pf_raddr = idx - 1'b1;
        waddr    = idx;
        if (idx == '0) begin
          // what is left of the running inverse belongs to the first element
          cmd.pf_we   = 1'b1;
          cmd.pf_wsel = PW_TOTAL;
          state_next  = S_EMIT_RD;
        end else begin
          state_next = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        pf_raddr      = idx - 1'b1;
        cmd.mul_start = 1'b1;
        cmd.a_sel     = MA_TOTAL;
        cmd.b_sel     = MB_PF;
        state_next    = S_W1_MW;
      end
      S_W1_MW: begin
        pf_raddr = idx - 1'b1;
        waddr    = idx;
        if (stat.mul_done) begin
          cmd.pf_we   = 1'b1;
          cmd.pf_wsel = PW_MUL;
          state_next  = S_W2_GO;
        end
      end
      S_W2_GO: begin
        cmd.mul_start = 1'b1;
        cmd.a_sel     = MA_TOTAL;
        cmd.b_sel     = MB_EL;
        state_next    = S_W2_MW;
      end
      S_W2_MW: begin
        if (stat.mul_done) begin
          cmd.total_mul = 1'b1;
          idx_next      = idx - 1'b1;
          state_next    = S_WALK;
        end
      end
      S_EMIT_RD: begin
        pf_raddr      = idx;
        emit_ld_next  = 1'b1;
        out_last_next = (idx == cm1[AW-1:0]);
        state_next    = S_OUT;
      end
      S_OUT: begin
        pf_raddr = idx;
        // inverse word lands in the cycle after the read was issued
        if (emit_ld) begin
          cmd.out_ld = 1'b1;
        end else if (out_ready) begin
          if (out_last_r) begin
            count_next     = '0;
            zero_seen_next = 1'b0;
            ovf_seen_next  = 1'b0;
            state_next     = S_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_EMIT_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      zero_seen  <= 1'b0;
      ovf_seen   <= 1'b0;
      out_last_r <= 1'b0;
      emit_ld    <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      zero_seen  <= zero_seen_next;
      ovf_seen   <= ovf_seen_next;
      out_last_r <= out_last_next;
      emit_ld    <= emit_ld_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    eidx   <= eidx_next;
    last_l <= last_l_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT) && !emit_ld;
  assign out_last  = out_last_r;
endmodule

// ===== rtl/pfbi_checker.sv =====
module pfbi_assertions import pfbi_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_last,
  input logic [1:0]        out_status,
  input logic [ELEM_W-1:0] out_word
);

  // an element is never taken while a result word is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while result pending");

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("error word not marked last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != ST_OK |-> out_word == '0)
    else $error("error word carries data");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == ST_OK || out_status == ST_ZERO || out_status == ST_LONG))
    else $error("bad status code");

  // more words of the batch follow, so no new element yet
  a_mid_batch: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("input reopened before batch end");

endmodule

bind prime_field_batch_inverter_core pfbi_assertions u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (result.ready),
  .out_last   (out_last),
  .out_status (out_status),
  .out_word   (out_word)
);

// ===== verif/pfbi_checker.sv =====
`timescale 1ns / 100ps

module pfbi_checker import pfbi_pkg::*; #(
  parameter int MAX_BATCH = 64
) (
  input  logic clk,
  input  logic rst,
  pfbi_in_if   elem,
  pfbi_out_if  result,
  pfbi_cfg_if  cfg,
  output int   fails,
  output int   pending
);

  typedef struct {
    logic [ELEM_W-1:0] inv;
    logic [1:0]        status;
    logic              last_result;
  } inv_word_t;

  inv_word_t         inv_q[$];
  logic [1:0]        field_sel;
  logic [ELEM_W-1:0] elem_mem[MAX_BATCH];
  logic [ELEM_W-1:0] pref_mem[MAX_BATCH];
  int                batch_len;
  bit                zero_flag;
  bit                long_flag;
  int                fail_cnt;

  function automatic logic [ELEM_W-1:0] field_prime(input logic [1:0] sel);
    case (sel)
      FIELD_BN:  return {128'd0, 64'h30644E72E131A029, 64'hB85045B68181585D,
                         64'h97816A916871CA8D, 64'h3C208C16D87CFD47};
      FIELD_BLS: return {64'h1A0111EA397FE69A, 64'h4B1BA7B6434BACD7,
                         64'h64774B84F38512BF, 64'h6730D2A0F6B0F624,
                         64'h1EABFFFEB153FFFF, 64'hB9FEFFFFFFFFAAAB};
      default:   return {128'd0, {3{64'hFFFFFFFFFFFFFFFF}}, 64'hFFFFFFFEFFFFFC2F};
    endcase
  endfunction

  function automatic logic [ELEM_W-1:0] mod_mul(input logic [ELEM_W-1:0] a,
                                                input logic [ELEM_W-1:0] b,
                                                input logic [ELEM_W-1:0] m);
    logic [2*ELEM_W-1:0] t;
    t = {{ELEM_W{1'b0}}, a} * {{ELEM_W{1'b0}}, b};
    t = t % {{ELEM_W{1'b0}}, m};
    return t[ELEM_W-1:0];
  endfunction

  // fermat: x^(p-2), exponent bits from lsb up
  function automatic logic [ELEM_W-1:0] mod_inv(input logic [ELEM_W-1:0] x,
                                                input logic [ELEM_W-1:0] m);
    logic [ELEM_W-1:0] e, r, b;
    e = m - ELEM_W'(2);
    r = ELEM_W'(1);
    b = x;
    for (int i = 0; i < ELEM_W; i++) begin
      if (e[i]) r = mod_mul(r, b, m);
      b = mod_mul(b, b, m);
    end
    return r;
  endfunction

  task automatic take_element(input logic [ELEM_W-1:0] raw, input logic last);
    logic [1:0]        sel;
    logic [ELEM_W-1:0] m, x, tot;
    logic [ELEM_W-1:0] invs[MAX_BATCH];
    inv_word_t         w;
    sel = (field_sel == FIELD_BN || field_sel == FIELD_BLS) ? field_sel : FIELD_SECP;
    m = field_prime(sel);
    x = (sel == FIELD_BLS) ? raw : {128'd0, raw[255:0]};
    if (batch_len >= MAX_BATCH) begin
      long_flag = 1;
    end else begin
      if (x == '0) zero_flag = 1;
      elem_mem[batch_len] = x;
      pref_mem[batch_len] = (batch_len == 0) ? x : mod_mul(pref_mem[batch_len-1], x, m);
      batch_len++;
    end
    if (!last) return;
    if (long_flag || zero_flag) begin
      w.inv = '0;
      w.status = long_flag ? ST_LONG : ST_ZERO;
      w.last_result = 1;
      inv_q.push_back(w);
    end else begin
      tot = mod_inv(pref_mem[batch_len-1], m);
      for (int i = batch_len - 1; i > 0; i--) begin
        invs[i] = mod_mul(tot, pref_mem[i-1], m);
        tot = mod_mul(tot, elem_mem[i], m);
      end
      invs[0] = tot;
      for (int i = 0; i < batch_len; i++) begin
        w.inv = invs[i];
        w.status = ST_OK;
        w.last_result = (i == batch_len - 1);
        inv_q.push_back(w);
      end
    end
    batch_len = 0;
    zero_flag = 0;
    long_flag = 0;
  endtask

  always @(posedge clk) begin
    inv_word_t         w;
    logic [ELEM_W-1:0] got;
    if (rst) begin
      field_sel = FIELD_SECP;
      batch_len = 0;
      zero_flag = 0;
      long_flag = 0;
      inv_q.delete();
      fail_cnt = 0;
    end else begin
      if (result.valid && result.ready) begin
        got = {result.inv_limb_5, result.inv_limb_4, result.inv_limb_3,
               result.inv_limb_2, result.inv_limb_1, result.inv_limb_0};
        if (inv_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_cnt++;
        end else begin
          w = inv_q.pop_front();
          for (int j = 0; j < NUM_LIMBS; j++)
            if (got[j*LIMB_W +: LIMB_W] !== w.inv[j*LIMB_W +: LIMB_W]) begin
              $error("inv_limb_%0d expected %h actual %h", j,
                     w.inv[j*LIMB_W +: LIMB_W], got[j*LIMB_W +: LIMB_W]);
              fail_cnt++;
            end
          if (result.status !== w.status) begin
            $error("status expected %0d actual %0d", w.status, result.status);
            fail_cnt++;
          end
          if (result.last_result !== w.last_result) begin
            $error("last_result expected %0d actual %0d", w.last_result,
                   result.last_result);
            fail_cnt++;
          end
        end
      end
      if (elem.valid && elem.ready)
        take_element({elem.limb_5, elem.limb_4, elem.limb_3, elem.limb_2,
                      elem.limb_1, elem.limb_0}, elem.is_last);
      if (cfg.valid && cfg.ready) field_sel = cfg.field_select;
    end
    pending <= inv_q.size();
    fails <= fail_cnt;
  end

endmodule

// ===== verif/tb_prime_field_batch_inverter_core.sv =====
`timescale 1ns / 100ps

module tb_prime_field_batch_inverter_core;
  import pfbi_pkg::*;

  localparam logic [ELEM_W-1:0] P_SECP = {128'd0, {3{64'hFFFFFFFFFFFFFFFF}},
                                          64'hFFFFFFFEFFFFFC2F};
  localparam logic [ELEM_W-1:0] P_BN = {128'd0, 64'h30644E72E131A029,
                                        64'hB85045B68181585D, 64'h97816A916871CA8D,
                                        64'h3C208C16D87CFD47};

  logic clk = 0;
  logic rst = 1;
  int   fails, pending;
  bit   calm = 0;
  bit   stall_arm = 0;
  int   n_words = 0, n_batches = 0;

  always #10 clk = ~clk;

  pfbi_in_if  elem_ch();
  pfbi_out_if res_ch();
  pfbi_cfg_if cfg_ch();

  prime_field_batch_inverter_core dut (
    .clk(clk), .rst(rst), .elem(elem_ch), .result(res_ch), .cfg(cfg_ch)
  );

  pfbi_checker chk (
    .clk(clk), .rst(rst), .elem(elem_ch), .result(res_ch), .cfg(cfg_ch),
    .fails(fails), .pending(pending)
  );

  function automatic logic [ELEM_W-1:0] rand_elem();
    logic [ELEM_W-1:0] v;
    for (int i = 0; i < 12; i++) v[i*32 +: 32] = $urandom;
    case ($urandom_range(9))
      0: v = ELEM_W'($urandom_range(1, 1000));
      1: v = '1;
      2: v[383:256] = '0;
      default: ;
    endcase
    return v;
  endfunction

  // result side: random backpressure, plus one long hold once armed
  initial begin
    res_ch.ready <= 0;
    @(posedge clk);
    forever begin
      if (stall_arm && res_ch.valid) begin
        res_ch.ready <= 0;
        repeat (5000) @(posedge clk);
        stall_arm = 0;
      end
      res_ch.ready <= calm || ($urandom_range(99) >= 22);
      @(posedge clk);
    end
  end

  task automatic send_word(input logic [ELEM_W-1:0] v, input bit last);
    if (!calm && $urandom_range(99) < 22) begin
      elem_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    elem_ch.valid <= 1;
    {elem_ch.limb_5, elem_ch.limb_4, elem_ch.limb_3,
     elem_ch.limb_2, elem_ch.limb_1, elem_ch.limb_0} <= v;
    elem_ch.is_last <= last;
    @(posedge clk);
    while (!elem_ch.ready) @(posedge clk);
    n_words++;
    if (last) n_batches++;
  endtask

  task automatic drain();
    elem_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_field(input logic [1:0] sel);
    drain();
    cfg_ch.valid <= 1;
    cfg_ch.field_select <= sel;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 0;
  endtask

  initial begin
    int len;
    elem_ch.valid <= 0;
    elem_ch.is_last <= 0;
    {elem_ch.limb_5, elem_ch.limb_4, elem_ch.limb_3,
     elem_ch.limb_2, elem_ch.limb_1, elem_ch.limb_0} <= '0;
    cfg_ch.valid <= 0;
    cfg_ch.field_select <= FIELD_SECP;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    set_field(FIELD_SECP);
    send_word(ELEM_W'(1), 0);
    send_word('1, 0);
    send_word(P_SECP + 1, 0);
    send_word(P_SECP - 1, 0);
    send_word(rand_elem(), 1);

    // multiples of p zero out the whole batch
    set_field(FIELD_BN);
    send_word(rand_elem(), 0);
    send_word(P_BN, 0);
    send_word(rand_elem(), 1);

    set_field(FIELD_BLS);
    send_word('1, 0);
    send_word({1'b1, 383'd0}, 0);
    send_word(rand_elem(), 1);

    // unused code; upper limbs ignored so this counts as zero
    set_field(2'd3);
    send_word(rand_elem(), 0);
    send_word({128'hFFFF_0000_0000_0001_8000_0000_0000_0000, 256'd0}, 0);
    send_word(rand_elem(), 1);

    set_field(FIELD_BLS);
    send_word({64'd0, 64'h8000_0000_0000_0001, 256'd0}, 1);

    set_field(FIELD_SECP);
    send_word({128'h1234, 256'd0}, 1);

    // overlong batch
    set_field(FIELD_BN);
    for (int i = 0; i < 66; i++) send_word(rand_elem(), i == 65);

    for (int b = 0; b < 7; b++) begin
      if (b != 2) set_field(2'($urandom_range(3)));
      calm = (b == 3);
      // stays armed until the result side has done its long hold
      if (b == 1) stall_arm = 1;
      len = (b == 0 || b == 6) ? 64 : (b == 4) ? $urandom_range(1, 8)
                                                : $urandom_range(40, 64);
      for (int i = 0; i < len; i++)
        send_word(($urandom_range(39) == 0) ? '0 : rand_elem(), i == len - 1);
    end
    calm = 0;

    drain();
    repeat (200) @(posedge clk);
    $display("covered %0d element words in %0d batches, all field selects,",
             n_words, n_batches);
    $display("zero, overlong and non-reduced elements under backpressure");
    if (fails == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #(64'd1_400_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pfbi_pkg.sv
rtl/pfbi_in_if.sv
rtl/pfbi_out_if.sv
rtl/pfbi_cfg_if.sv
rtl/pfbi_ram.sv
rtl/pfbi_modmul.sv
rtl/pfbi_datapath.sv
rtl/pfbi_ctrl.sv
rtl/prime_field_batch_inverter_core.sv
rtl/pfbi_checker.sv
verif/pfbi_checker.sv
verif/tb_prime_field_batch_inverter_core.sv
